[rtl/core/bblc_pkg.sv]
// Shared constants, types and codes of the byte budget LRU cache.
package bblc_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SIZE_W  = 32;
    localparam int BYTES_W = SIZE_W + 1;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    localparam logic [SIZE_W-1:0] BUDGET_RESET = 32'd1048576;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [SIZE_W-1:0]   item_size_t;
    typedef logic [BYTES_W-1:0]  bytes_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [IDX_W-1:0]    rank_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_NOP     = 3'd0,
        ST_PROMOTE = 3'd1,
        ST_FLUSH   = 3'd2,
        ST_EVICT   = 3'd3,
        ST_INSERT  = 3'd4
    } store_op_t;

    typedef struct packed {
        store_op_t  op;
        idx_t       idx;
        rank_t      rank;
        key_t       key;
        item_size_t size;
    } store_ctrl_t;

    typedef struct packed {
        logic       match;
        logic       free;
        idx_t       victim_idx;
        item_size_t victim_size;
    } store_stat_t;

endpackage

[rtl/core/byte_budget_lru_cache.sv]
// Top level of the byte budget LRU cache: sequencer, byte accounting and ports.
//
// The block caches item keys under a byte budget and reports, for every request
// item taken on the s_ channel, one result item on the m_ channel. A request
// carries a key and the item's byte size. A hit makes the entry most recent; a
// miss inserts it, evicting least recent entries until the bytes fit the
// budget, or flushes the whole table when the item alone exceeds the budget.
// The user writes the budget via cfg_wr_en/cfg_wr_data only while the block
// is idle; the block itself does not enforce this.
// Each request first walks the table one entry per cycle looking for the key:
// a hit stops the walk at the matching entry, a miss walks all ENTRIES entries.
// A hit then promotes the entry; a miss compares the size with the budget and
// either flushes, or frees a slot in a full table, inserts the item and evicts
// least recent entries while the bytes exceed the budget, each add and subtract
// on the one shared unit. The result shows up as s_tready rises again.
// Only one request is in work at a time; s_tready is high while idle.
// The result sits in an output register, so a new request may be taken while
// the receiver stalls; its result waits until the previous one is taken.
// Reset empties the table, clears the byte total and sets the budget to 1 MiB.
module byte_budget_lru_cache (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration: byte_budget.
    input  logic                                cfg_wr_en,
    input  logic [31:0]                         cfg_wr_data,
    // Request: item_key [31:0], item_size [63:32].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bblc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result: evicted_count [4:0], bytes_now_used [36:5],
    // entries_now_used [41:37], zero fill above.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bblc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Result flags: was_hit [0], oversize_flush [1].
    output logic [bblc_pkg::OUT_TUSER_W-1:0]    m_tuser
);
    import bblc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_SCAN       = 9'b000000010,
        S_HIT        = 9'b000000100,
        S_CHECK      = 9'b000001000,
        S_MAKE_ROOM  = 9'b000010000,
        S_INSERT     = 9'b000100000,
        S_TRIM_CHK   = 9'b001000000,
        S_TRIM_EVICT = 9'b010000000,
        S_DONE       = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    cnt_t       count_reg, count_next;
    bytes_t     bytes_reg, bytes_next;
    item_size_t budget_reg, budget_next;
    logic       m_tvalid_reg, m_tvalid_next;

    key_t       key_reg, key_next;
    item_size_t size_reg, size_next;
    idx_t       scan_idx_reg, scan_idx_next;
    idx_t       slot_reg, slot_next;
    logic       free_found_reg, free_found_next;
    logic       hit_reg, hit_next;
    logic       flush_reg, flush_next;
    cnt_t       evicted_reg, evicted_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    store_ctrl_t st_ctrl;
    store_stat_t st_stat;

    alu_op_t alu_op;
    bytes_t  alu_a, alu_b, alu_res;
    logic    alu_borrow;

    logic s_accept;
    logic out_free;

    bblc_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (st_ctrl),
        .stat    (st_stat)
    );

    bblc_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Operand selection for the shared unit. A borrow on budget minus x means
    // x is over budget.
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, budget_reg};
        alu_b  = bytes_reg;
        case (state_reg)
            S_CHECK: begin
                alu_b = {1'b0, size_reg};
            end
            S_MAKE_ROOM, S_TRIM_EVICT: begin
                alu_a = bytes_reg;
                alu_b = {1'b0, st_stat.victim_size};
            end
            S_INSERT: begin
                alu_op = ALU_ADD;
                alu_a  = bytes_reg;
                alu_b  = {1'b0, size_reg};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        budget_next     = cfg_wr_en ? cfg_wr_data : budget_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        key_next        = key_reg;
        size_next       = size_reg;
        scan_idx_next   = scan_idx_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        hit_next        = hit_reg;
        flush_next      = flush_reg;
        evicted_next    = evicted_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        st_ctrl.op   = ST_NOP;
        st_ctrl.idx  = scan_idx_reg;
        st_ctrl.rank = IDX_W'(count_reg - 1'b1);
        st_ctrl.key  = key_reg;
        st_ctrl.size = size_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    key_next        = KEY_BITS'(s_tdata[31:0]);
                    size_next       = s_tdata[63:32];
                    scan_idx_next   = '0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    flush_next      = 1'b0;
                    evicted_next    = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (st_stat.match) begin
                    slot_next  = scan_idx_reg;
                    state_next = S_HIT;
                end else begin
                    if (st_stat.free && !free_found_reg) begin
                        slot_next       = scan_idx_reg;
                        free_found_next = 1'b1;
                    end
                    if (scan_idx_reg == IDX_W'(ENTRIES - 1)) begin
                        state_next = S_CHECK;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end
            S_HIT: begin
                st_ctrl.op  = ST_PROMOTE;
                st_ctrl.idx = slot_reg;
                hit_next    = 1'b1;
                state_next  = S_DONE;
            end
            S_CHECK: begin
                if (alu_borrow) begin
                    // The item alone is over budget: empty everything.
                    st_ctrl.op   = ST_FLUSH;
                    flush_next   = 1'b1;
                    evicted_next = count_reg;
                    count_next   = '0;
                    bytes_next   = '0;
                    state_next   = S_DONE;
                end else if (count_reg == CNT_W'(ENTRIES)) begin
                    state_next = S_MAKE_ROOM;
                end else begin
                    state_next = S_INSERT;
                end
            end
            S_MAKE_ROOM: begin
                st_ctrl.op   = ST_EVICT;
                slot_next    = st_stat.victim_idx;
                bytes_next   = alu_res;
                count_next   = count_reg - 1'b1;
                evicted_next = evicted_reg + 1'b1;
                state_next   = S_INSERT;
            end
            S_INSERT: begin
                st_ctrl.op  = ST_INSERT;
                st_ctrl.idx = slot_reg;
                bytes_next  = alu_res;
                count_next  = count_reg + 1'b1;
                state_next  = S_TRIM_CHK;
            end
            S_TRIM_CHK: begin
                if (alu_borrow && (count_reg != '0)) begin
                    state_next = S_TRIM_EVICT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_TRIM_EVICT: begin
                st_ctrl.op   = ST_EVICT;
                bytes_next   = alu_res;
                count_next   = count_reg - 1'b1;
                evicted_next = evicted_reg + 1'b1;
                state_next   = S_TRIM_CHK;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_TDATA_W - 42){1'b0}}, 5'(count_reg),
                                     bytes_reg[31:0], 5'(evicted_reg)};
                    m_tuser_next  = {flush_reg, hit_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            bytes_reg    <= '0;
            budget_reg   <= BUDGET_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            bytes_reg    <= bytes_next;
            budget_reg   <= budget_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        size_reg       <= size_next;
        scan_idx_reg   <= scan_idx_next;
        slot_reg       <= slot_next;
        free_found_reg <= free_found_next;
        hit_reg        <= hit_next;
        flush_reg      <= flush_next;
        evicted_reg    <= evicted_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // An empty table holds no bytes.
    a_empty_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (bytes_reg == '0))
        else $error("byte total nonzero with no valid entries");

    // A flush result reports an empty cache.
    a_flush_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> ((m_tdata[36:5] == '0) && (m_tdata[41:37] == '0)))
        else $error("flush result reports a nonempty cache");

    // A hit never evicts and never flushes.
    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata[4:0] == '0) && !m_tuser[1]))
        else $error("hit result shows evictions or a flush");

    // After an insert the table never holds more than its entry count.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INSERT) |=> (count_reg <= CNT_W'(ENTRIES)))
        else $error("entry count above table size");

endmodule

[rtl/core/bblc_alu.sv]
// Shared add/subtract unit for byte totals and budget compares.
module bblc_alu (
    input  bblc_pkg::alu_op_t op,
    input  bblc_pkg::bytes_t  a,
    input  bblc_pkg::bytes_t  b,
    output bblc_pkg::bytes_t  res,
    output logic              borrow
);
    import bblc_pkg::*;

    logic [BYTES_W:0] wide;

    always_comb begin
        if (op == ALU_SUB) begin
            wide = {1'b0, a} - {1'b0, b};
        end else begin
            wide = {1'b0, a} + {1'b0, b};
        end
    end

    // A borrow out of a subtract means b was larger than a.
    assign res    = wide[BYTES_W-1:0];
    assign borrow = (op == ALU_SUB) && wide[BYTES_W];

endmodule

[rtl/core/bblc_store.sv]
// Entry table: keys, sizes, valid bits and recency ranks.
module bblc_store (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bblc_pkg::store_ctrl_t ctrl,
    output bblc_pkg::store_stat_t stat
);
    import bblc_pkg::*;

    key_t             key_mem  [ENTRIES];
    item_size_t       size_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    rank_t            rank_reg  [ENTRIES];
    rank_t            rank_next [ENTRIES];
    logic [ENTRIES-1:0] oldest_vec;
    idx_t             victim_idx;
    rank_t            promote_rank;

    // Valid ranks are always a permutation of 0..count-1, so the oldest entry is
    // the one whose rank equals the rank asked for by the sequencer.
    always_comb begin
        victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            oldest_vec[i] = valid_reg[i] && (rank_reg[i] == ctrl.rank);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (oldest_vec[i]) begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    assign stat.match       = valid_reg[ctrl.idx] && (key_mem[ctrl.idx] == ctrl.key);
    assign stat.free        = !valid_reg[ctrl.idx];
    assign stat.victim_idx  = victim_idx;
    assign stat.victim_size = size_mem[victim_idx];

    always_comb begin
        valid_next   = valid_reg;
        rank_next    = rank_reg;
        promote_rank = rank_reg[ctrl.idx];
        case (ctrl.op)
            ST_PROMOTE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && (rank_reg[i] < promote_rank)) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[ctrl.idx] = '0;
            end
            ST_FLUSH: begin
                valid_next = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    rank_next[i] = '0;
                end
            end
            ST_EVICT: begin
                valid_next[victim_idx] = 1'b0;
                rank_next[victim_idx]  = '0;
            end
            ST_INSERT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                valid_next[ctrl.idx] = 1'b1;
                rank_next[ctrl.idx]  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == ST_INSERT) begin
            key_mem[ctrl.idx]  <= ctrl.key;
            size_mem[ctrl.idx] <= ctrl.size;
        end
    end

endmodule

[sim/tb.sv]
// Self-checking testbench for the byte budget LRU cache, with its own cache predictor.
//
// Requests are queued by the stimulus process and offered on the s_ channel by a
// clocked driver. A clocked monitor runs the cache predictor for every request
// item that the block takes, and it checks every result item against the oldest
// expected result. Both sides idle at random. A directed opening covers the
// field extremes, hits, oversize flushes, full-table eviction and a budget
// lowered under the bytes in use. After that come random phases, each under a
// different budget.
module tb;
    import bblc_pkg::*;

    // A generous bound on the whole run, far above the slowest legal run.
    localparam int CYCLE_LIMIT  = 900_000;
    // Length of a deliberate receiver hold-off, long enough to back up the block.
    localparam int HOLD_CYCLES  = 300;
    // Worst-case request latency plus margin.
    localparam int SETTLE_TICKS = 3 * ENTRIES + 12;
    localparam int PHASE_ITEMS  = 178;

    typedef struct packed {
        item_size_t size;
        key_t       key;
    } request_t;

    typedef struct packed {
        logic        hit;
        logic        flush;
        cnt_t        evicted;
        logic [31:0] bytes;
        cnt_t        entries;
    } access_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    byte_budget_lru_cache dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predicted cache contents. A rank of 0 marks the most recent valid entry.
    key_t        cache_key  [ENTRIES];
    item_size_t  cache_size [ENTRIES];
    bit          cache_live [ENTRIES];
    int unsigned cache_rank [ENTRIES];
    bytes_t      bytes_held = '0;
    item_size_t  budget = BUDGET_RESET;

    request_t       request_q[$];
    access_result_t pending_results[$];

    int  n_offered = 0;
    int  n_taken = 0;
    int  n_checked = 0;
    int  err_count = 0;
    int  cycles = 0;
    bit  req_fired = 1'b0;
    bit  quiet = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  hold_left = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            cache_key[i] = '0;
            cache_size[i] = '0;
            cache_live[i] = 1'b0;
            cache_rank[i] = 0;
        end
    end

    function automatic int count_live();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (cache_live[i]) n++;
        return n;
    endfunction

    // Drops the least recent valid entry and takes its bytes off the total;
    // returns 0 if the table is empty.
    function automatic bit drop_oldest();
        int victim;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (cache_live[i] && (victim < 0 || cache_rank[i] > cache_rank[victim]))
                victim = i;
        if (victim < 0) return 1'b0;
        cache_live[victim] = 1'b0;
        bytes_held = bytes_held - cache_size[victim];
        cache_rank[victim] = 0;
        return 1'b1;
    endfunction

    // Applies one request to the predicted cache and returns the result it must report.
    function automatic access_result_t serve_request(key_t key, item_size_t size);
        access_result_t res;
        int found;
        int slot;
        int unsigned r;
        res = '0;
        found = -1;
        slot = ENTRIES;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && cache_live[i] && cache_key[i] == key) found = i;
        if (found >= 0) begin
            // A hit moves the entry to the front; every entry more recent moves back.
            r = cache_rank[found];
            res.hit = 1'b1;
            for (int i = 0; i < ENTRIES; i++)
                if (cache_live[i] && cache_rank[i] < r) cache_rank[i]++;
            cache_rank[found] = 0;
        end else if (size > budget) begin
            // An item larger than the whole budget empties the table and is not kept.
            res.flush = 1'b1;
            res.evicted = cnt_t'(count_live());
            for (int i = 0; i < ENTRIES; i++) begin
                cache_live[i] = 1'b0;
                cache_rank[i] = 0;
            end
            bytes_held = '0;
        end else begin
            if (count_live() >= ENTRIES && drop_oldest()) res.evicted = res.evicted + 1'b1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot == ENTRIES && !cache_live[i]) slot = i;
            if (slot < ENTRIES) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (cache_live[i]) cache_rank[i]++;
                cache_live[slot] = 1'b1;
                cache_key[slot] = key;
                cache_size[slot] = size;
                cache_rank[slot] = 0;
                bytes_held = bytes_held + size;
                // The new item fits the budget alone, so this loop never drops it.
                while (bytes_held > budget && drop_oldest()) res.evicted = res.evicted + 1'b1;
            end
        end
        res.bytes = bytes_held[31:0];
        res.entries = cnt_t'(count_live());
        return res;
    endfunction

    task automatic report(input string what);
        $display("result %0d: %s", n_checked, what);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic check_result();
        access_result_t want;
        if (pending_results.size() == 0) begin
            report("result item with no request outstanding");
        end else begin
            want = pending_results.pop_front();
            check_field("was_hit", m_tuser[0], want.hit);
            check_field("oversize_flush", m_tuser[1], want.flush);
            check_field("evicted_count", m_tdata[4:0], want.evicted);
            check_field("bytes_now_used", m_tdata[36:5], want.bytes);
            check_field("entries_now_used", m_tdata[41:37], want.entries);
            check_field("zero fill", m_tdata[OUT_TDATA_W-1:42], '0);
        end
        n_checked++;
    endtask

    // Idle stretches are mostly short, now and then medium, and rarely long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sizes cluster around the budget so that exact fits, overflows and
    // eviction chains all show up, with plenty of tiny items to fill the table.
    function automatic item_size_t pick_size(item_size_t b);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return b;
        if (r < 15) return (b == '1) ? b : b + 1'b1;
        if (r < 20) return $urandom();
        if (r < 23) return '1;
        if (r < 50) return $urandom_range(0, 255);
        return $urandom_range(0, b / $urandom_range(1, 20));
    endfunction

    // Cycle counter and watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor: both channels are sampled at the rising edge. Each request taken
    // feeds the predictor, and each result taken is checked in arrival order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(serve_request(s_tdata[31:0], s_tdata[63:32]));
                n_taken++;
            end
            req_fired <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) check_result();
        end
    end

    // Request driver: inputs change at the falling edge. An offered item stays
    // up until it is taken; after that a random gap may follow.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fired) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (request_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {request_q[0].size, request_q[0].key};
                request_q.delete(0);
                gap_left <= (!quiet && $urandom_range(0, 99) < 40) ? idle_len() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request of the
    // stimulus, counted here so that the sender keeps offering meanwhile.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            stall_left <= idle_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic queue_request(input key_t key, input item_size_t size);
        request_t req;
        req.key = key;
        req.size = size;
        request_q.push_back(req);
        n_offered++;
    endtask

    // Waits until every queued request is taken and every result is back, then
    // lets the block finish its return to idle.
    task automatic wait_drained();
        while (n_taken != n_offered || pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // The budget is only written while the block is idle, so the predictor can
    // take the new value at once.
    task automatic set_budget(input item_size_t value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        budget = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase(input item_size_t b);
        key_t key_pool[40];
        int pool_n;
        key_t key;
        set_budget(b);
        // A small pool gives frequent hits; a large one makes the table thrash.
        pool_n = $urandom_range(6, 40);
        for (int i = 0; i < 40; i++) key_pool[i] = $urandom();
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
                                                : key_t'($urandom());
            queue_request(key, pick_size(b));
        end
    endtask

    item_size_t budget_plan[8];

    initial begin
        budget_plan[0] = 32'd0;
        budget_plan[1] = 32'd1;
        budget_plan[2] = 32'd700;
        budget_plan[3] = BUDGET_RESET;
        budget_plan[4] = 32'hFFFF_FFFF;
        budget_plan[5] = $urandom();
        budget_plan[6] = 32'd5000;
        budget_plan[7] = 32'h8000_0000;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening under the reset budget of 1 MiB. A zero-size item is
        // stored like any other, and an item of exactly the budget still fits.
        queue_request(32'h0000_0000, 32'd0);
        queue_request(32'hFFFF_FFFF, BUDGET_RESET);
        // A hit ignores the size it carries.
        queue_request(32'h0000_0000, 32'd5);
        // One byte over the budget flushes both entries; the next flush finds nothing.
        queue_request(32'h0000_0001, BUDGET_RESET + 1);
        queue_request(32'h0000_0002, 32'hFFFF_FFFF);
        // Sixteen items fill the table; two more evict the oldest each time.
        for (int k = 10; k < 28; k++) queue_request(key_t'(k), 32'd100);
        queue_request(key_t'(20), 32'd7);
        wait_drained();

        // A lower budget evicts nothing until the next miss; a hit keeps the
        // bytes in use above it.
        set_budget(32'd500);
        queue_request(key_t'(25), 32'd0);
        queue_request(32'h5555_AAAA, 32'd50);
        queue_request(32'hAAAA_5555, 32'd501);
        wait_drained();

        foreach (budget_plan[p]) begin
            // One phase runs with no idling on either side.
            quiet = (p == 6);
            run_random_phase(budget_plan[p]);
            // In two phases the receiver holds off while requests keep coming,
            // so the result register fills and the block stalls its input.
            if (p == 2 || p == 5) hold_asked++;
            wait_drained();
        end
        quiet = 1'b0;

        // Give a stray result time to show up before the verdict.
        repeat (SETTLE_TICKS) @(negedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/bblc_pkg.sv
rtl/core/bblc_alu.sv
rtl/core/bblc_store.sv
rtl/core/byte_budget_lru_cache.sv
sim/tb.sv
